>>> design/tcce_pkg.sv
// Shared constants, codes and types of the text console character engine.
// No dependencies; imported by every module of the block except tcce_ram.
package tcce_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int LAST_ROW   = CELL_COUNT - COLUMNS;

  localparam int ADDR_W   = $clog2(CELL_COUNT);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;
  localparam logic [7:0]        SPACE_CHAR = 8'h20;
  localparam logic [7:0]        CH_NUL     = 8'h00;
  localparam logic [7:0]        CH_BS      = 8'h08;
  localparam logic [7:0]        CH_NL      = 8'h0A;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CHAR,
    OP_BS,
    OP_NL,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [7:0]        attr;
    logic [7:0]        ch;
    logic [ADDR_W-1:0] idx;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR
  } state_t;

endpackage

>>> design/tcce_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/tcce_front.sv
// Front end: accepts request words, decodes them into commands and queues them.
// Depends on tcce_pkg.
module tcce_front import tcce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [7:0]  char_code,
  input  logic [3:0]  fore_colour,
  input  logic [3:0]  back_colour,
  input  logic [10:0] cell_index,
  input  logic        init_busy,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t       q [2];
  cmd_t       cmd_in;
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push_ok;

  always_comb begin
    cmd_in.attr = {back_colour, fore_colour};
    cmd_in.ch   = char_code;
    cmd_in.idx  = ADDR_W'(cell_index);
    case (req_type)
      REQ_PUT: begin
        priority if (char_code == CH_NUL) cmd_in.op = OP_NOP;
        else if (char_code == CH_BS) cmd_in.op = OP_BS;
        else if (char_code == CH_NL) cmd_in.op = OP_NL;
        else cmd_in.op = OP_CHAR;
      end
      REQ_CLEAR: cmd_in.op = OP_CLEAR;
      REQ_READ:  cmd_in.op = (32'(cell_index) < CELL_COUNT) ? OP_READ : OP_NOP;
      default:   cmd_in.op = OP_NOP;
    endcase
  end

  assign full      = (cnt == 2'd2) || init_busy;
  assign push_ok   = push && !full;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push_ok) wp <= ~wp;
      if (cmd_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push_ok} - {1'b0, cmd_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q[wp] <= cmd_in;
  end

endmodule

>>> design/tcce_back.sv
// Back end: executes queued commands on the screen RAM, tracks the cursor,
// sequences scroll and clear sweeps and queues result words. Depends on tcce_pkg, tcce_ram.
module tcce_back import tcce_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  cmd_t                cmd,
  output logic                cmd_pop,
  output logic                init_busy,
  output logic                empty,
  input  logic                pop,
  output logic [CURSOR_W-1:0] cursor_index,
  output logic [CELL_W-1:0]   cell_data
);

  state_t            state, state_next;
  logic              clr_req, clr_req_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ADDR_W-1:0] pos, pos_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic              pend, pend_next;
  logic [ADDR_W-1:0] wr_addr, wr_addr_next;
  logic [7:0]        attr, attr_next;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rdata;

  logic                res_push;
  logic [CELL_W-1:0]   res_data;
  logic [CURSOR_W-1:0] res_cur [2];
  logic [CELL_W-1:0]   res_dat [2];
  logic                res_wp, res_rp;
  logic [1:0]          res_cnt;
  logic                pop_ok;
  logic                go;

  tcce_ram #(.WIDTH(CELL_W), .DEPTH(CELL_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign go        = cmd_valid && (res_cnt != 2'd2);
  assign init_busy = (state == ST_CLEAR) && !clr_req;

  always_comb begin
    state_next   = state;
    clr_req_next = clr_req;
    row_next     = row;
    col_next     = col;
    pos_next     = pos;
    ptr_next     = ptr;
    pend_next    = pend;
    wr_addr_next = wr_addr;
    attr_next    = attr;
    we           = 1'b0;
    waddr        = pos;
    wdata        = '0;
    raddr        = ptr;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res_data     = '0;
    unique case (state)
      ST_IDLE: begin
        if (go) begin
          cmd_pop   = 1'b1;
          attr_next = cmd.attr;
          case (cmd.op)
            OP_CHAR: begin
              we    = 1'b1;
              waddr = pos;
              wdata = {cmd.attr, cmd.ch};
              if (col == COL_W'(COLUMNS - 1)) begin
                col_next = '0;
                if (row == ROW_W'(ROWS - 1)) begin
                  pos_next   = ADDR_W'(LAST_ROW);
                  ptr_next   = '0;
                  pend_next  = 1'b0;
                  state_next = ST_SCROLL;
                end else begin
                  row_next = row + 1'b1;
                  pos_next = pos + 1'b1;
                  res_push = 1'b1;
                end
              end else begin
                col_next = col + 1'b1;
                pos_next = pos + 1'b1;
                res_push = 1'b1;
              end
            end
            OP_BS: begin
              if (col != '0) begin
                col_next = col - 1'b1;
                pos_next = pos - 1'b1;
                we       = 1'b1;
                waddr    = pos - 1'b1;
                wdata    = {cmd.attr, SPACE_CHAR};
              end
              res_push = 1'b1;
            end
            OP_NL: begin
              col_next = '0;
              if (row == ROW_W'(ROWS - 1)) begin
                pos_next   = ADDR_W'(LAST_ROW);
                ptr_next   = '0;
                pend_next  = 1'b0;
                state_next = ST_SCROLL;
              end else begin
                row_next = row + 1'b1;
                pos_next = pos - ADDR_W'(col) + ADDR_W'(COLUMNS);
                res_push = 1'b1;
              end
            end
            OP_CLEAR: begin
              row_next     = '0;
              col_next     = '0;
              pos_next     = '0;
              ptr_next     = '0;
              clr_req_next = 1'b1;
              state_next   = ST_CLEAR;
            end
            OP_READ: begin
              raddr      = cmd.idx;
              state_next = ST_READ;
            end
            default: res_push = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        res_push   = 1'b1;
        res_data   = rdata;
        state_next = ST_IDLE;
      end
      ST_SCROLL: begin
        // read one row below, write the word fetched last cycle
        raddr = ptr + ADDR_W'(COLUMNS);
        we    = pend;
        waddr = wr_addr;
        wdata = rdata;
        if (ptr == ADDR_W'(LAST_ROW)) begin
          pend_next  = 1'b0;
          state_next = ST_FILL;
        end else begin
          pend_next    = 1'b1;
          wr_addr_next = ptr;
          ptr_next     = ptr + 1'b1;
        end
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = {attr, SPACE_CHAR};
        if (ptr == ADDR_W'(CELL_COUNT - 1)) begin
          res_push   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = BLANK_CELL;
        if (ptr == ADDR_W'(CELL_COUNT - 1)) begin
          res_push     = clr_req;
          clr_req_next = 1'b0;
          state_next   = ST_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign pop_ok       = pop && !empty;
  assign empty        = (res_cnt == 2'd0);
  assign cursor_index = res_cur[res_rp];
  assign cell_data    = res_dat[res_rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_req <= 1'b0;
      row     <= '0;
      col     <= '0;
      pos     <= '0;
      ptr     <= '0;
      pend    <= 1'b0;
      res_wp  <= 1'b0;
      res_rp  <= 1'b0;
      res_cnt <= 2'd0;
    end else begin
      state   <= state_next;
      clr_req <= clr_req_next;
      row     <= row_next;
      col     <= col_next;
      pos     <= pos_next;
      ptr     <= ptr_next;
      pend    <= pend_next;
      if (res_push) res_wp <= ~res_wp;
      if (pop_ok) res_rp <= ~res_rp;
      res_cnt <= res_cnt + {1'b0, res_push} - {1'b0, pop_ok};
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= wr_addr_next;
    attr    <= attr_next;
    if (res_push) begin
      res_cur[res_wp] <= CURSOR_W'(pos_next);
      res_dat[res_wp] <= res_data;
    end
  end

endmodule

>>> design/text_console_char_engine.sv
// Top level of the text console character engine: front decoder, back executor.
// Depends on tcce_pkg, tcce_front, tcce_back.
//
// Usage: request words enter through a queue-style port (push/full); each
// word is put character, clear screen or read cell. Every request yields one
// result word (cursor_index, cell_data) on a queue-style port (empty/pop).
// Path: a request word is registered in the command queue, executed by the
// back end and its result registered in the result queue. The back end takes
// a request only while idle and the result queue has room; put and NUL
// finish in ST_IDLE, a read also passes through ST_READ for the registered
// screen RAM read. A put that moves past the last row scrolls, one cell per
// cycle through the RAM copy loop. A clear request sweeps all CELL_COUNT
// cells, one per cycle.
// Reset: synchronous, active high. After reset the screen RAM is swept to
// 0x0700, all CELL_COUNT cells, during which full stays high.
// Stall: a two-entry command queue and a two-entry result queue decouple the
// sides; with results not popped, at most four requests are held before full.
module text_console_char_engine import tcce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [7:0]  char_code,
  input  logic [3:0]  fore_colour,
  input  logic [3:0]  back_colour,
  input  logic [10:0] cell_index,
  output logic        empty,
  input  logic        pop,
  output logic [10:0] cursor_index,
  output logic [15:0] cell_data
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic init_busy;

  tcce_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .char_code   (char_code),
    .fore_colour (fore_colour),
    .back_colour (back_colour),
    .cell_index  (cell_index),
    .init_busy   (init_busy),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  tcce_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .init_busy    (init_busy),
    .empty        (empty),
    .pop          (pop),
    .cursor_index (cursor_index),
    .cell_data    (cell_data)
  );

endmodule
